[hdl/bsp_pkg.sv]
// bsp_pkg: shared constants, codes and types of the binary spur pruner
// no dependencies; imported by every module of the block
`default_nettype none

package bsp_pkg;

    // image bounds (columns are memory words, rows are bits of a word)
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    // address and index widths
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    // dimension arithmetic must hold a register value and a coordinate plus 3
    localparam int CFG_W  = 9;
    localparam int XDW    = $clog2(MAX_WIDTH + 3);
    localparam int YDW    = $clog2(MAX_HEIGHT + 3);
    localparam int DW0    = (XDW > YDW) ? XDW : YDW;
    localparam int DIM_W  = (DW0 > CFG_W) ? DW0 : CFG_W;

    // field widths of the streams
    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 8;
    localparam int CNT_W    = 17;
    localparam int S_USER_W = FUNC_W;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    // command codes carried in tuser
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PRUNE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // one image column
    typedef logic [MAX_HEIGHT-1:0] col_t;

    // write request into the column store, bit-masked
    typedef struct packed {
        logic          en;
        logic [XW-1:0] addr;
        col_t          mask;
        col_t          data;
    } col_wr_t;

    // controls of the three-column window
    typedef struct packed {
        logic load_left;
        logic load_mid;
        logic load_right;
        logic step;
        logic advance;
        logic test_en;
    } win_ctl_t;

    // status of the three-column window
    typedef struct packed {
        logic hit;
        col_t col_done;
    } win_sts_t;

endpackage

`default_nettype wire

[hdl/binary_spur_pruner_core.sv]
// binary_spur_pruner_core: top level, command sequencer, counters and result register
// depends on bsp_pkg, bsp_col_store and bsp_col_window
//
//  channel | dir | handshake          | payload, lowest bit first
//  s_      | in  | s_tvalid/s_tready  | tuser: func; tdata: col, row, pixel_in
//  m_      | out | m_tvalid/m_tready  | tdata: pixel_out, removed_total, pass_total
//  cfg_    | in  | cfg_wr_en          | cfg_wr_index, cfg_wr_data
//
// write: result registered directly; read: goes through the registered memory read and ST_RD
// prune: each pass loads the left, middle and right columns and then scans; no scan when W or H
//   is below 3; the window steps one row per cycle and the store delivers one column per read
// aresetn is synchronous; image contents are not cleared by reset
// a stalled result blocks new transactions; the input stays ready meanwhile only if
//   the result is taken in the same cycle
`default_nettype none

module binary_spur_pruner_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bsp_pkg::S_DATA_W-1:0]      s_tdata,   // col, row, pixel_in, zero pad
    input  logic [bsp_pkg::S_USER_W-1:0]      s_tuser,   // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bsp_pkg::M_DATA_W-1:0]      m_tdata,   // pixel_out, removed_total,
                                                         // pass_total, zero pad
    input  logic                              cfg_wr_en,
    input  logic [bsp_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [bsp_pkg::CFG_W-1:0]         cfg_wr_data
);
    import bsp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RD     = 7'b0000010,
        ST_PSTART = 7'b0000100,
        ST_L0     = 7'b0001000,
        ST_L1     = 7'b0010000,
        ST_L2     = 7'b0100000,
        ST_SCAN   = 7'b1000000
    } state_t;

    localparam logic [YW-1:0] STEP_LAST = YW'(MAX_HEIGHT - 1);

    state_t               state_reg, state_next;
    logic                 pend_reg, pend_next;
    logic [DIM_W-1:0]     x_reg, x_next;
    logic [YW-1:0]        step_reg, step_next;
    logic [CNT_W-1:0]     rem_acc_reg, rem_acc_next;
    logic [CNT_W-1:0]     pass_acc_reg, pass_acc_next;
    logic                 changed_reg, changed_next;
    logic [CNT_W-1:0]     removed_count_reg, removed_count_next;
    logic [CNT_W-1:0]     pass_count_reg, pass_count_next;
    logic [CFG_W-1:0]     width_reg, height_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [YW-1:0]        rd_row_reg, rd_row_next;
    logic                 rd_inside_reg, rd_inside_next;

    logic [DIM_W-1:0]     eff_w, eff_h;
    logic                 s_accept;
    logic [FUNC_W-1:0]    s_func;
    logic [COORD_W-1:0]   s_col, s_row;
    logic                 s_pixel_in;
    logic                 s_inside;
    logic [CNT_W-1:0]     pass_inc;

    logic                 rd_en;
    logic [XW-1:0]        rd_addr;
    col_t                 rd_data;
    col_wr_t              wr;
    win_ctl_t             ctl;
    win_sts_t             sts;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [M_DATA_W-1:0] pack_out(input logic pix,
                                                     input logic [CNT_W-1:0] rem,
                                                     input logic [CNT_W-1:0] pas);
        pack_out = M_DATA_W'({pas, rem, pix});
    endfunction

    bsp_col_store u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_data (rd_data)
    );

    bsp_col_window u_window (
        .aclk    (aclk),
        .ctl     (ctl),
        .rd_data (rd_data),
        .sts     (sts)
    );

    // field unpacking and effective dimensions
    assign s_func     = s_tuser;
    assign s_col      = s_tdata[COORD_W-1:0];
    assign s_row      = s_tdata[2*COORD_W-1:COORD_W];
    assign s_pixel_in = s_tdata[2*COORD_W];
    assign eff_w = (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                            : DIM_W'(width_reg);
    assign eff_h = (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                              : DIM_W'(height_reg);
    assign s_inside = (DIM_W'(s_col) < eff_w) && (DIM_W'(s_row) < eff_h);
    assign pass_inc = sat_inc(pass_acc_reg);

    assign s_tready = (state_reg == ST_IDLE) && !pend_reg && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // command sequencer
    always_comb begin
        state_next         = state_reg;
        pend_next          = 1'b0;
        x_next             = x_reg;
        step_next          = step_reg;
        rem_acc_next       = rem_acc_reg;
        pass_acc_next      = pass_acc_reg;
        changed_next       = changed_reg;
        removed_count_next = removed_count_reg;
        pass_count_next    = pass_count_reg;
        m_valid_next       = m_valid_reg && !m_tready;
        m_data_next        = m_data_reg;
        rd_row_next        = rd_row_reg;
        rd_inside_next     = rd_inside_reg;
        rd_en              = 1'b0;
        rd_addr            = '0;
        wr                 = '0;
        ctl                = '0;

        // end of a pass: repeat or deliver the prune result
        if (pend_reg) begin
            if (changed_reg) begin
                pass_acc_next = pass_inc;
                state_next    = ST_PSTART;
            end else begin
                removed_count_next = rem_acc_reg;
                pass_count_next    = pass_inc;
                m_valid_next       = 1'b1;
                m_data_next        = pack_out(1'b0, rem_acc_reg, pass_inc);
                state_next         = ST_IDLE;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_func)
                        FUNC_WRITE: begin
                            wr.en        = s_inside;
                            wr.addr      = XW'(s_col);
                            wr.mask      = col_t'(1) << YW'(s_row);
                            wr.data      = {MAX_HEIGHT{s_pixel_in}};
                            m_valid_next = 1'b1;
                            m_data_next  = pack_out(1'b0, removed_count_reg, pass_count_reg);
                        end
                        FUNC_READ: begin
                            rd_en          = 1'b1;
                            rd_addr        = XW'(s_col);
                            rd_row_next    = YW'(s_row);
                            rd_inside_next = s_inside;
                            state_next     = ST_RD;
                        end
                        FUNC_PRUNE: begin
                            rem_acc_next  = '0;
                            pass_acc_next = '0;
                            changed_next  = 1'b0;
                            state_next    = ST_PSTART;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next  = pack_out(1'b0, removed_count_reg, pass_count_reg);
                        end
                    endcase
                end
            end
            ST_RD: begin
                m_valid_next = 1'b1;
                m_data_next  = pack_out(rd_inside_reg & rd_data[rd_row_reg],
                                        removed_count_reg, pass_count_reg);
                state_next   = ST_IDLE;
            end
            ST_PSTART: begin
                // a new pass starts only once the previous pass end has resolved
                if (!pend_reg) begin
                    changed_next = 1'b0;
                    if (eff_w < DIM_W'(3) || eff_h < DIM_W'(3)) begin
                        pend_next  = 1'b1;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = XW'(0);
                        state_next = ST_L0;
                    end
                end
            end
            ST_L0: begin
                ctl.load_left = 1'b1;
                rd_en         = 1'b1;
                rd_addr       = XW'(1);
                state_next    = ST_L1;
            end
            ST_L1: begin
                ctl.load_mid = 1'b1;
                rd_en        = 1'b1;
                rd_addr      = XW'(2);
                state_next   = ST_L2;
            end
            ST_L2: begin
                ctl.load_right = 1'b1;
                x_next         = DIM_W'(1);
                step_next      = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                // keep the column after next in the read register
                rd_en       = 1'b1;
                rd_addr     = XW'(x_reg + DIM_W'(2));
                ctl.step    = 1'b1;
                ctl.test_en = (DIM_W'(step_reg) + DIM_W'(3)) <= eff_h;
                if (sts.hit) begin
                    rem_acc_next = sat_inc(rem_acc_reg);
                    changed_next = 1'b1;
                end
                if (step_reg == STEP_LAST) begin
                    ctl.advance = 1'b1;
                    wr.en       = 1'b1;
                    wr.addr     = XW'(x_reg);
                    wr.mask     = '1;
                    wr.data     = sts.col_done;
                    step_next   = '0;
                    if ((x_reg + DIM_W'(2)) >= eff_w) begin
                        pend_next  = 1'b1;
                        state_next = ST_PSTART;
                    end else begin
                        x_next = x_reg + DIM_W'(1);
                    end
                end else begin
                    step_next = step_reg + YW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a pending pass end holds the sequencer until it resolves
        if (pend_next) begin
            state_next = ST_PSTART;
        end else if (pend_reg) begin
            state_next = changed_reg ? ST_PSTART : ST_IDLE;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            pend_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
            removed_count_reg <= '0;
            pass_count_reg    <= '0;
            width_reg         <= CFG_W'(MAX_WIDTH > 256 ? 256 : 256);
            height_reg        <= CFG_W'(256);
        end else begin
            state_reg         <= state_next;
            pend_reg          <= pend_next;
            m_valid_reg       <= m_valid_next;
            removed_count_reg <= removed_count_next;
            pass_count_reg    <= pass_count_next;
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    CFG_IDX_WIDTH:  width_reg  <= cfg_wr_data;
                    CFG_IDX_HEIGHT: height_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        step_reg      <= step_next;
        rem_acc_reg   <= rem_acc_next;
        pass_acc_reg  <= pass_acc_next;
        changed_reg   <= changed_next;
        m_data_reg    <= m_data_next;
        rd_row_reg    <= rd_row_next;
        rd_inside_reg <= rd_inside_next;
    end

`ifndef SYNTHESIS
    // a waiting result is never overwritten by a new transaction
    a_no_accept_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("transaction accepted while result stalled");

    // during a scan the store is written only when a column completes
    a_scan_write_at_column_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && step_reg != STEP_LAST) |-> !wr.en)
        else $error("column written before its scan finished");

    // no cycle reads and writes the same column
    a_no_same_column_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && rd_en) |-> (wr.addr != rd_addr))
        else $error("read and write hit the same column");

    // a finishing prune delivers a result with at least one pass
    a_prune_result_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && !changed_reg) |=> (m_tvalid && pass_count_reg != '0))
        else $error("prune finished without a counted pass");
`endif

endmodule

`default_nettype wire

[hdl/bsp_col_store.sv]
// bsp_col_store: image memory, one column per word, bit-masked writes
// depends on bsp_pkg; one write and one registered read per cycle
`default_nettype none

module bsp_col_store (
    input  logic                    aclk,
    input  logic                    rd_en,
    input  logic [bsp_pkg::XW-1:0]  rd_addr,
    input  bsp_pkg::col_wr_t        wr,
    output bsp_pkg::col_t           rd_data
);
    import bsp_pkg::*;

    col_t mem [MAX_WIDTH];
    col_t rd_data_reg;

    // masked write, registered read
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            for (int i = 0; i < MAX_HEIGHT; i++) begin
                if (wr.mask[i]) begin
                    mem[wr.addr][i] <= wr.data[i];
                end
            end
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/bsp_col_window.sv]
// bsp_col_window: left, middle and right column registers with the endpoint test
// depends on bsp_pkg; columns rotate one row per step so the 3x3 window sits at bits 0..2
`default_nettype none

module bsp_col_window (
    input  logic               aclk,
    input  bsp_pkg::win_ctl_t  ctl,
    input  bsp_pkg::col_t      rd_data,
    output bsp_pkg::win_sts_t  sts
);
    import bsp_pkg::*;

    col_t left_reg, mid_reg, right_reg;
    col_t mid_mod, mid_step;
    logic hit;

    function automatic col_t rot(input col_t v);
        rot = {v[0], v[MAX_HEIGHT-1:1]};
    endfunction

    // nb order: up, dn, lf, rt, ul, ur, dl, dr
    function automatic logic is_spur(input logic [7:0] nb);
        logic [3:0] n;
        logic       up, dn, lf, rt, ul, ur, dl, dr;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, nb[i]};
        end
        up = nb[0]; dn = nb[1]; lf = nb[2]; rt = nb[3];
        ul = nb[4]; ur = nb[5]; dl = nb[6]; dr = nb[7];
        if (n <= 4'd1) begin
            is_spur = 1'b1;
        end else if (n == 4'd2) begin
            is_spur = (ul && (up || lf)) || (ur && (up || rt)) ||
                      (dl && (dn || lf)) || (dr && (dn || rt));
        end else begin
            is_spur = 1'b0;
        end
    endfunction

    // endpoint test on the center pixel, bit 1 of the middle column
    always_comb begin
        hit = ctl.test_en && mid_reg[1] &&
              is_spur({right_reg[0], left_reg[0], right_reg[2], left_reg[2],
                       right_reg[1], left_reg[1], mid_reg[0], mid_reg[2]});
        mid_mod = mid_reg;
        if (hit) begin
            mid_mod[1] = 1'b0;
        end
        mid_step = rot(mid_mod);
    end

    // column loads, row steps and column advance
    always_ff @(posedge aclk) begin
        if (ctl.load_left) begin
            left_reg <= rd_data;
        end
        if (ctl.load_mid) begin
            mid_reg <= rd_data;
        end
        if (ctl.load_right) begin
            right_reg <= rd_data;
        end
        if (ctl.step) begin
            if (ctl.advance) begin
                left_reg  <= mid_step;
                mid_reg   <= rot(right_reg);
                right_reg <= rd_data;
            end else begin
                left_reg  <= rot(left_reg);
                mid_reg   <= mid_step;
                right_reg <= rot(right_reg);
            end
        end
    end

    assign sts.hit      = hit;
    assign sts.col_done = mid_step;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for binary_spur_pruner_core, with driver, monitor and predictor
// depends on bsp_pkg and the RTL of the block; a mirror of the image checks every status
`timescale 1ns / 1ps

module tb_top;
    import bsp_pkg::*;

    // unused command code, the block must leave everything alone
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int GAP_MAX        = 6;
    localparam int MAX_REPORTS    = 40;
    // 5x5 test shape, bit x*5+y
    localparam logic [24:0] SHAPE_5X5 = 25'b10001_01100_00110_01010_00011;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               pix;
    } cmd_t;

    typedef struct {
        logic             pix;
        logic [CNT_W-1:0] removed;
        logic [CNT_W-1:0] passes;
    } status_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;   // col, row, pixel_in, zero pad
    logic [S_USER_W-1:0]  s_tuser = '0;   // func
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;        // pixel_out, removed_total, pass_total, zero pad
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    binary_spur_pruner_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 8 ns clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // mirror of the block state
    bit               img_mirror [0:MAX_WIDTH-1][0:MAX_HEIGHT-1];
    logic [CFG_W-1:0] width_reg  = 9'd256;
    logic [CFG_W-1:0] height_reg = 9'd256;
    logic [CNT_W-1:0] removed_cnt = '0;
    logic [CNT_W-1:0] pass_cnt    = '0;

    // bench bookkeeping
    cmd_t        cmd_queue [$];
    status_t     status_due [$];
    cmd_t        cur_cmd;
    int unsigned cmds_issued = 0;
    int unsigned cmds_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned gap_max = 0;
    int unsigned stall_max = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned stuck_cycles = 0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;

    function automatic int clamp_dim(logic [CFG_W-1:0] v, int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    // end point or isolated pixel test on an interior pixel
    function automatic bit is_spur(int x, int y);
        bit up, dn, lf, rt, ul, ur, dl, dr;
        int n;
        up = img_mirror[x][y+1];
        dn = img_mirror[x][y-1];
        lf = img_mirror[x-1][y];
        rt = img_mirror[x+1][y];
        ul = img_mirror[x-1][y+1];
        ur = img_mirror[x+1][y+1];
        dl = img_mirror[x-1][y-1];
        dr = img_mirror[x+1][y-1];
        n = up + dn + lf + rt + ul + ur + dl + dr;
        if (n <= 1)
            return 1'b1;
        return (n == 2) && ((ul && (up || lf)) || (ur && (up || rt)) ||
                            (dl && (dn || lf)) || (dr && (dn || rt)));
    endfunction

    // passes until one clears nothing, updates in place, x outer and y inner
    function automatic void prune_image();
        int w, h, removed, passes, this_pass;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        removed = 0;
        passes = 0;
        do begin
            this_pass = 0;
            if (w >= 3 && h >= 3) begin
                for (int x = 1; x + 1 < w; x++) begin
                    for (int y = 1; y + 1 < h; y++) begin
                        if (img_mirror[x][y] && is_spur(x, y)) begin
                            img_mirror[x][y] = 1'b0;
                            this_pass++;
                        end
                    end
                end
            end
            removed += this_pass;
            if (removed > int'(CNT_MAX))
                removed = int'(CNT_MAX);
            if (passes < int'(CNT_MAX))
                passes++;
        end while (this_pass != 0);
        removed_cnt = removed[CNT_W-1:0];
        pass_cnt = passes[CNT_W-1:0];
    endfunction

    // updates the mirror for one command and returns the status it must produce
    function automatic status_t apply_command(cmd_t c);
        status_t s;
        bit in_img;
        int w, h;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        in_img = (int'(c.col) < w) && (int'(c.row) < h);
        s.pix = 1'b0;
        case (c.func)
            FUNC_WRITE: begin
                if (in_img)
                    img_mirror[c.col][c.row] = c.pix;
            end
            FUNC_PRUNE: begin
                prune_image();
            end
            FUNC_READ: begin
                if (in_img)
                    s.pix = img_mirror[c.col][c.row];
            end
            default: begin
            end
        endcase
        s.removed = removed_cnt;
        s.passes = pass_cnt;
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // command driver, one gap drawn per transaction
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_queue.size() != 0) begin
                cur_cmd = cmd_queue.pop_front();
                s_tdata <= {7'd0, cur_cmd.pix, cur_cmd.row, cur_cmd.col};
                s_tuser <= cur_cmd.func;
                s_tvalid <= 1'b1;
                gap_left <= $urandom_range(0, gap_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // accepted command: predict its status
    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            status_due.push_back(apply_command(cur_cmd));
            cmds_accepted++;
        end
    end

    // result ready, one stall drawn per transaction
    always @(negedge aclk) begin : out_ready
        int unsigned n;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (out_taken || !m_tready) begin
            n = out_taken ? $urandom_range(0, stall_max) : stall_left;
            if (n != 0) begin
                m_tready <= 1'b0;
                stall_left <= n - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // status check against the oldest prediction
    always @(posedge aclk) begin : out_check
        status_t want;
        out_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_due.size() == 0) begin
                report_mismatch("unrequested status", m_tdata[CNT_W-1:0], '0);
            end else begin
                want = status_due.pop_front();
                if (m_tdata[0] !== want.pix)
                    report_mismatch("pixel_out", CNT_W'(m_tdata[0]), CNT_W'(want.pix));
                if (m_tdata[17:1] !== want.removed)
                    report_mismatch("removed_total", m_tdata[17:1], want.removed);
                if (m_tdata[34:18] !== want.passes)
                    report_mismatch("pass_total", m_tdata[34:18], want.passes);
                if (m_tdata[M_DATA_W-1:35] !== '0)
                    report_mismatch("tdata pad", CNT_W'(m_tdata[M_DATA_W-1:35]), '0);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("binary_spur_pruner_core verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_cmd(logic [FUNC_W-1:0] f, int c, int r, bit p);
        cmd_t t;
        t.func = f;
        t.col = c[COORD_W-1:0];
        t.row = r[COORD_W-1:0];
        t.pix = p;
        cmd_queue.push_back(t);
        cmds_issued++;
    endtask

    task automatic wait_idle();
        while (cmds_accepted != cmds_issued || status_due.size() != 0)
            @(negedge aclk);
    endtask

    // register writes only with nothing in flight
    task automatic set_dims(int w, int h);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= CFG_IDX_WIDTH;
        cfg_wr_data <= w[CFG_W-1:0];
        width_reg = w[CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_index <= CFG_IDX_HEIGHT;
        cfg_wr_data <= h[CFG_W-1:0];
        height_reg = h[CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // writes every pixel of the image in use
    task automatic load_image(int fill_pct, bit clear_border);
        int w, h;
        bit on_border, p;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        for (int x = 0; x < w; x++) begin
            for (int y = 0; y < h; y++) begin
                on_border = (x == 0) || (y == 0) || (x == w - 1) || (y == h - 1);
                p = ($urandom_range(0, 99) < fill_pct) && !(clear_border && on_border);
                push_cmd(FUNC_WRITE, x, y, p);
            end
        end
    endtask

    // short straight or diagonal line of set pixels
    task automatic push_stroke(int w, int h);
        int x, y, dx, dy, len;
        x = $urandom_range(0, w - 1);
        y = $urandom_range(0, h - 1);
        dx = int'($urandom_range(0, 2)) - 1;
        dy = int'($urandom_range(0, 2)) - 1;
        if (dx == 0 && dy == 0)
            dx = 1;
        len = $urandom_range(2, 5);
        for (int i = 0; i < len && x >= 0 && y >= 0 && x < w && y < h; i++) begin
            push_cmd(FUNC_WRITE, x, y, 1'b1);
            x += dx;
            y += dy;
        end
    endtask

    // random mix of writes, reads, strokes, prunes and unused codes
    task automatic random_ops(int count, int fill_pct);
        int w, h, sel, c, r;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85) begin
                c = $urandom_range(0, w - 1);
                r = $urandom_range(0, h - 1);
            end else begin
                c = $urandom_range(0, 255);
                r = $urandom_range(0, 255);
            end
            if (sel < 6)
                push_cmd(FUNC_PRUNE, c, r, 1'($urandom_range(0, 1)));
            else if (sel < 10)
                push_cmd(FUNC_NONE, c, r, 1'($urandom_range(0, 1)));
            else if (sel < 18)
                push_stroke(w, h);
            else if (sel < 60)
                push_cmd(FUNC_WRITE, c, r, $urandom_range(0, 99) < fill_pct);
            else
                push_cmd(FUNC_READ, c, r, 1'($urandom_range(0, 1)));
        end
    endtask

    // stimulus sequence
    initial begin : stimulus
        int tiny_w [4] = '{2, 0, 4, 6};
        int tiny_h [4] = '{4, 7, 0, 1};
        int w, h, fill;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset size: corner pixels and alternating bit patterns
        push_cmd(FUNC_WRITE, 255, 255, 1'b1);
        push_cmd(FUNC_READ, 255, 255, 1'b0);
        push_cmd(FUNC_WRITE, 0, 0, 1'b1);
        push_cmd(FUNC_READ, 0, 0, 1'b0);
        push_cmd(FUNC_WRITE, 0, 0, 1'b0);
        push_cmd(FUNC_READ, 0, 0, 1'b1);
        push_cmd(FUNC_WRITE, 170, 85, 1'b1);
        push_cmd(FUNC_READ, 170, 85, 1'b0);
        push_cmd(FUNC_NONE, 255, 255, 1'b1);
        push_cmd(FUNC_WRITE, 85, 170, 1'b0);
        push_cmd(FUNC_READ, 85, 170, 1'b1);

        // fixed 5x5 shape, prune twice, coordinates off the image
        gap_max = GAP_MAX;
        stall_max = GAP_MAX;
        set_dims(5, 5);
        for (int x = 0; x < 5; x++)
            for (int y = 0; y < 5; y++)
                push_cmd(FUNC_WRITE, x, y, SHAPE_5X5[x * 5 + y]);
        push_cmd(FUNC_PRUNE, 0, 0, 1'b0);
        push_cmd(FUNC_READ, 2, 2, 1'b0);
        push_cmd(FUNC_READ, 3, 3, 1'b0);
        push_cmd(FUNC_READ, 1, 1, 1'b0);
        push_cmd(FUNC_PRUNE, 0, 0, 1'b0);
        push_cmd(FUNC_WRITE, 7, 1, 1'b1);
        push_cmd(FUNC_READ, 7, 1, 1'b0);
        push_cmd(FUNC_READ, 4, 4, 1'b0);
        push_cmd(FUNC_WRITE, 1, 200, 1'b1);
        push_cmd(FUNC_NONE, 0, 0, 1'b0);

        // sizes with no interior
        foreach (tiny_w[i]) begin
            set_dims(tiny_w[i], tiny_h[i]);
            load_image(50, 1'b0);
            push_cmd(FUNC_PRUNE, 0, 0, 1'b0);
            push_cmd(FUNC_READ, 0, 0, 1'b0);
        end

        // oversized size registers behave as the full image
        set_dims(511, 511);
        push_cmd(FUNC_WRITE, 200, 255, 1'b1);
        push_cmd(FUNC_READ, 200, 255, 1'b0);
        push_cmd(FUNC_READ, 255, 255, 1'b0);
        push_cmd(FUNC_WRITE, 255, 200, 1'b1);
        push_cmd(FUNC_READ, 255, 200, 1'b0);
        push_cmd(FUNC_NONE, 255, 255, 1'b0);

        // random phases on small images, pacing varies per phase
        for (int p = 0; p < 8; p++) begin
            w = (p == 0) ? 3 : $urandom_range(3, 10);
            h = (p == 0) ? 3 : (p == 1) ? 16 : $urandom_range(3, 16);
            gap_max = (p % 3 == 1) ? 0 : GAP_MAX;
            stall_max = (p % 3 == 2) ? 0 : GAP_MAX;
            fill = $urandom_range(20, 70);
            set_dims(w, h);
            load_image(fill, 1'b0);
            random_ops(30, fill);
        end

        wait_idle();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0)
            $display("binary_spur_pruner_core verification clean");
        else
            $display("binary_spur_pruner_core verification failed");
        $finish;
    end

endmodule
